// ----- rtl/hsfd_pkg.sv -----
// shared types, constants and crc helper for the humidity sensor frame decoder
package hsfd_pkg;

  localparam logic [7:0] CrcPolyReset = 8'h31;
  localparam logic [7:0] CrcInit      = 8'hFF;
  localparam logic [2:0] LastPos      = 3'd5;
  localparam int unsigned TempScale   = 17500;
  localparam int unsigned HumScale    = 10000;
  localparam int signed   TempOffset  = 4500;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic               crc_error;
  } out_t;

  // one complete reply, captured at the sixth byte
  typedef struct packed {
    logic [15:0] raw_t;
    logic [7:0]  crc_t;
    logic [15:0] raw_h;
    logic [7:0]  crc_h;
  } frame_t;

  // partial crc over the high bytes plus the scaled raw words
  typedef struct packed {
    logic [7:0]  rem_t;
    logic [7:0]  lo_t;
    logic [7:0]  crc_t;
    logic [30:0] prod_t;
    logic [7:0]  rem_h;
    logic [7:0]  lo_h;
    logic [7:0]  crc_h;
    logic [29:0] prod_h;
  } mid_t;

  // eight msb-first crc-8 steps over one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] rem_in,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] r;
    r = rem_in ^ data;
    for (int k = 0; k < 8; k++) begin
      r = r[7] ? ({r[6:0], 1'b0} ^ poly) : {r[6:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ----- rtl/hsfd_capture.sv -----
// byte counter, reply byte store and captured-frame register
module hsfd_capture
  import hsfd_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  in_t    in_data_i,
  output logic   in_stall_o,
  output logic   frame_valid_o,
  output frame_t frame_o,
  input  logic   frame_ready_i
);

  logic [2:0] pos_q, pos_d;
  logic [2:0] pos_eff;
  logic [7:0] store_q [5];
  logic       frame_valid_q, frame_valid_d;
  frame_t     frame_q;
  logic       ready;
  logic       accept;
  logic       load;

  assign ready      = !frame_valid_q || frame_ready_i;
  assign in_stall_o = !ready;
  assign accept     = in_valid_i && ready;

  // start flag or a stray count restarts at byte 0
  assign pos_eff = (in_data_i.frame_start || pos_q > LastPos) ? 3'd0 : pos_q;
  assign load    = accept && (pos_eff == LastPos);

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = load ? 3'd0 : pos_eff + 3'd1;
    end
    frame_valid_d = load || (frame_valid_q && !frame_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= 3'd0;
      frame_valid_q <= 1'b0;
    end else begin
      pos_q         <= pos_d;
      frame_valid_q <= frame_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !load) begin
      store_q[pos_eff] <= in_data_i.rx_byte;
    end
    if (load) begin
      frame_q.raw_t <= {store_q[0], store_q[1]};
      frame_q.crc_t <= store_q[2];
      frame_q.raw_h <= {store_q[3], store_q[4]};
      frame_q.crc_h <= in_data_i.rx_byte;
    end
  end

  assign frame_valid_o = frame_valid_q;
  assign frame_o       = frame_q;

endmodule

// ----- rtl/hsfd_scale.sv -----
// crc over the high bytes and scaling multiplies, one register stage
module hsfd_scale
  import hsfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] poly_i,
  input  logic       frame_valid_i,
  input  frame_t     frame_i,
  output logic       frame_ready_o,
  output logic       mid_valid_o,
  output mid_t       mid_o,
  input  logic       mid_ready_i
);

  logic mid_valid_q, mid_valid_d;
  mid_t mid_q, mid_d;
  logic ready;
  logic load;

  assign ready         = !mid_valid_q || mid_ready_i;
  assign frame_ready_o = ready;
  assign load          = frame_valid_i && ready;

  always_comb begin
    mid_d.rem_t  = crc8_byte(CrcInit, frame_i.raw_t[15:8], poly_i);
    mid_d.lo_t   = frame_i.raw_t[7:0];
    mid_d.crc_t  = frame_i.crc_t;
    mid_d.prod_t = 31'(TempScale) * {15'd0, frame_i.raw_t};
    mid_d.rem_h  = crc8_byte(CrcInit, frame_i.raw_h[15:8], poly_i);
    mid_d.lo_h   = frame_i.raw_h[7:0];
    mid_d.crc_h  = frame_i.crc_h;
    mid_d.prod_h = 30'(HumScale) * {14'd0, frame_i.raw_h};
    mid_valid_d  = load || (mid_valid_q && !mid_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else begin
      mid_valid_q <= mid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mid_q <= mid_d;
    end
  end

  assign mid_valid_o = mid_valid_q;
  assign mid_o       = mid_q;

endmodule

// ----- rtl/hsfd_result.sv -----
// crc finish and compare, divide by 65535, held values and result register
module hsfd_result
  import hsfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] poly_i,
  input  logic       mid_valid_i,
  input  mid_t       mid_i,
  output logic       mid_ready_o,
  output logic       out_valid_o,
  output out_t       out_data_o,
  input  logic       out_stall_i
);

  logic               out_valid_q, out_valid_d;
  out_t               res_q, res_d;
  logic               ready;
  logic               load;
  logic [7:0]         fin_t, fin_h;
  logic               err;
  logic [30:0]        sum_t;
  logic [29:0]        sum_h;
  logic signed [15:0] temp_full;

  assign ready       = !out_valid_q || !out_stall_i;
  assign mid_ready_o = ready;
  assign load        = mid_valid_i && ready;

  always_comb begin
    fin_t = crc8_byte(mid_i.rem_t, mid_i.lo_t, poly_i);
    fin_h = crc8_byte(mid_i.rem_h, mid_i.lo_h, poly_i);
    err   = (fin_t != mid_i.crc_t) || (fin_h != mid_i.crc_h);
    // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 over this range
    sum_t = mid_i.prod_t + {16'd0, mid_i.prod_t[30:16]} + 31'd1;
    sum_h = mid_i.prod_h + {16'd0, mid_i.prod_h[29:16]} + 30'd1;
    temp_full = $signed({1'b0, sum_t[30:16]}) - 16'(TempOffset);
    res_d = res_q;
    res_d.crc_error = err;
    if (!err) begin
      res_d.temperature_centi = temp_full[14:0];
      res_d.humidity_centi    = sum_h[29:16];
    end
    out_valid_d = load || (out_valid_q && out_stall_i);
  end

  // the result register doubles as the last good values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load) begin
        res_q <= res_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

// ----- rtl/humidity_sensor_frame_decoder.sv -----
// top level of the humidity sensor frame decoder
//
//   channel | direction | handshake            | payload
//   in      | sink      | in_valid_i/in_stall_o | in_t: rx_byte, frame_start
//   out     | source    | out_valid_o/out_stall_i | out_t: temperature, humidity, crc_error
//   cfg     | sink      | cfg_valid_i/cfg_ready_o | crc polynomial, 8 bits
//
// one byte per cycle while in_stall_o is low; the result for the sixth byte of a reply
// is registered in turn by capture, high-byte crc and multiply, and finish
// reset clears the byte count, pipeline valids and held values; polynomial to 0x31
// each stage holds while the one after it is full and stalled, so bytes keep
// flowing into empty stages while a result waits at the output
module humidity_sensor_frame_decoder
  import hsfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  in_t        in_data_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  output out_t       out_data_o,
  input  logic       out_stall_i,
  input  logic       cfg_valid_i,
  input  logic [7:0] cfg_data_i,
  output logic       cfg_ready_o
);

  logic [7:0] poly_q;
  logic       frame_valid;
  frame_t     frame;
  logic       frame_ready;
  logic       mid_valid;
  mid_t       mid;
  logic       mid_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= CrcPolyReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      poly_q <= cfg_data_i;
    end
  end

  hsfd_capture u_capture (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_data_i     (in_data_i),
    .in_stall_o    (in_stall_o),
    .frame_valid_o (frame_valid),
    .frame_o       (frame),
    .frame_ready_i (frame_ready)
  );

  hsfd_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .poly_i        (poly_q),
    .frame_valid_i (frame_valid),
    .frame_i       (frame),
    .frame_ready_o (frame_ready),
    .mid_valid_o   (mid_valid),
    .mid_o         (mid),
    .mid_ready_i   (mid_ready)
  );

  hsfd_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .poly_i      (poly_q),
    .mid_valid_i (mid_valid),
    .mid_i       (mid),
    .mid_ready_o (mid_ready),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
